>>> rtl/lct_pkg.sv
`default_nettype none

package lct_pkg;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;
   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);

   localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic {
      FUNC_GET = 1'b0,
      FUNC_PUT = 1'b1
   } func_type;

   typedef struct packed {
      func_type                      func;
      logic [KEY_BITS-1:0]           lookup_key;
      logic signed [VALUE_BITS-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [VALUE_BITS-1:0]  read_value;
      logic                          evicted;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_BITS-1:0]   rank;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

`default_nettype wire

>>> rtl/lct_ram.sv
`default_nettype none

module lct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/lfu_cache_table_top.sv
// LFU key-value cache with least-recently-used tiebreak among equal use counts.
// Request channel: an operation (get or put, key, value) transfers at a rising
// edge where start is high and busy is low. The block then holds busy high
// until the operation is complete; one operation is handled at a time.
// Response channel: exactly one result per operation appears on rsp_payload for
// a single cycle, marked by rsp_valid. The receiver cannot stall, and busy is
// already low in that cycle, so the next operation may transfer there.
// Each operation sweeps the entry memory once over its single read port, one
// slot per cycle, to find the key and the eviction victim; an operation that
// changes state sweeps it a second time to rewrite the recency ranks. A get
// that misses or a put while the capacity is zero strobes its result after
// the first sweep; every other operation strobes it after the second.
// Configuration: csr_data sets the capacity and transfers whenever csr_valid is
// high (csr_ready is always high); write it only while the block is idle.
// Reset empties the cache at once and sets the capacity to sixteen entries.
`default_nettype none

module lfu_cache_table_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire lct_pkg::req_type               req_payload,
   output logic                                rsp_valid,
   output lct_pkg::rsp_type                    rsp_payload,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lct_pkg::CAP_BITS-1:0]   csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE
   } state_type;

   state_type                          state_ff, state_in;
   logic [lct_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [lct_pkg::IDX_BITS-1:0]       rd_idx_ff, rd_idx_in;
   logic [lct_pkg::SLOTS-1:0]          valid_ff, valid_in;
   logic [lct_pkg::CAP_BITS-1:0]       cap_ff, cap_in;
   lct_pkg::req_type                   req_ff, req_in;
   logic [lct_pkg::CNT_W-1:0]          nvalid_ff, nvalid_in;
   logic                               found_ff, found_in;
   logic [lct_pkg::IDX_BITS-1:0]       found_idx_ff, found_idx_in;
   lct_pkg::entry_type                 found_ent_ff, found_ent_in;
   logic                               vic_ff, vic_in;
   logic [lct_pkg::IDX_BITS-1:0]       vic_idx_ff, vic_idx_in;
   logic [lct_pkg::COUNT_BITS-1:0]     vic_cnt_ff, vic_cnt_in;
   logic [lct_pkg::IDX_BITS-1:0]       vic_rank_ff, vic_rank_in;
   logic [lct_pkg::IDX_BITS-1:0]       tgt_idx_ff, tgt_idx_in;
   logic                               insert_ff, insert_in;
   logic                               evict_ff, evict_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   lct_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                               ram_wr_en;
   logic [lct_pkg::IDX_BITS-1:0]       ram_wr_addr;
   lct_pkg::entry_type                 ram_wr_data;
   logic [lct_pkg::ENTRY_BITS-1:0]     ram_rd_data;

   lct_ram #(
      .WIDTH (lct_pkg::ENTRY_BITS),
      .DEPTH (lct_pkg::SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_ff[lct_pkg::IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      lct_pkg::entry_type              rd_ent;
      lct_pkg::entry_type              upd_ent;
      logic                            issue;
      logic [lct_pkg::CNT_W-1:0]       cap_eff;
      logic [lct_pkg::SLOTS-1:0]       vmask;
      logic                            free_ok;
      logic [lct_pkg::IDX_BITS-1:0]    free_idx;
      logic                            evict_w;
      logic [lct_pkg::COUNT_BITS-1:0]  inc_cnt;
      logic [lct_pkg::IDX_BITS-1:0]    q;

      rd_ent   = lct_pkg::entry_type'(ram_rd_data);
      upd_ent  = rd_ent;
      issue    = (cnt_ff < lct_pkg::CNT_W'(lct_pkg::SLOTS));
      cap_eff  = (32'(cap_ff) > 32'(lct_pkg::SLOTS)) ? lct_pkg::CNT_W'(lct_pkg::SLOTS)
                                                    : lct_pkg::CNT_W'(cap_ff);
      vmask    = valid_ff;
      free_ok  = 1'b0;
      free_idx = '0;
      evict_w  = 1'b0;
      inc_cnt  = (found_ent_ff.count == lct_pkg::COUNT_MAX) ? found_ent_ff.count
                                                            : found_ent_ff.count + 1'b1;
      q        = rd_ent.rank;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      valid_in     = valid_ff;
      cap_in       = csr_valid ? csr_data : cap_ff;
      req_in       = req_ff;
      nvalid_in    = nvalid_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_ent_in = found_ent_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_cnt_in   = vic_cnt_ff;
      vic_rank_in  = vic_rank_ff;
      tgt_idx_in   = tgt_idx_ff;
      insert_in    = insert_ff;
      evict_in     = evict_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = tgt_idx_ff;
      ram_wr_data  = upd_ent;

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               req_in    = req_payload;
               nvalid_in = '0;
               found_in  = 1'b0;
               vic_in    = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in     = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[lct_pkg::IDX_BITS-1:0];
            end
            if (rd_pend_ff && valid_ff[rd_idx_ff]) begin
               nvalid_in = nvalid_ff + 1'b1;
               if (!found_ff && rd_ent.key == req_ff.lookup_key) begin
                  found_in     = 1'b1;
                  found_idx_in = rd_idx_ff;
                  found_ent_in = rd_ent;
               end
               if (!vic_ff || rd_ent.count < vic_cnt_ff ||
                   (rd_ent.count == vic_cnt_ff && rd_ent.rank > vic_rank_ff)) begin
                  vic_in      = 1'b1;
                  vic_idx_in  = rd_idx_ff;
                  vic_cnt_in  = rd_ent.count;
                  vic_rank_in = rd_ent.rank;
               end
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cnt_in         = '0;
            rsp_in.hit     = found_ff;
            rsp_in.evicted = 1'b0;
            rsp_in.read_value = (req_ff.func == lct_pkg::FUNC_GET && found_ff)
                                ? $signed(found_ent_ff.value) : '0;
            if (found_ff && (req_ff.func == lct_pkg::FUNC_GET || cap_eff != '0)) begin
               ram_wr_en        = 1'b1;
               ram_wr_addr      = found_idx_ff;
               ram_wr_data.key  = found_ent_ff.key;
               ram_wr_data.value = (req_ff.func == lct_pkg::FUNC_PUT)
                                   ? req_ff.write_value : found_ent_ff.value;
               ram_wr_data.count = inc_cnt;
               ram_wr_data.rank  = '0;
               tgt_idx_in       = found_idx_ff;
               insert_in        = 1'b0;
               evict_in         = 1'b0;
               state_in         = ST_UPDATE;
            end else if (req_ff.func == lct_pkg::FUNC_PUT && cap_eff != '0) begin
               evict_w = (nvalid_ff >= cap_eff) && vic_ff;
               if (evict_w) begin
                  vmask[vic_idx_ff] = 1'b0;
               end
               for (int i = lct_pkg::SLOTS - 1; i >= 0; i--) begin
                  if (!vmask[i]) begin
                     free_ok  = 1'b1;
                     free_idx = lct_pkg::IDX_BITS'(i);
                  end
               end
               if (free_ok) begin
                  valid_in           = vmask;
                  valid_in[free_idx] = 1'b1;
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_idx;
                  ram_wr_data.key    = req_ff.lookup_key;
                  ram_wr_data.value  = req_ff.write_value;
                  ram_wr_data.count  = lct_pkg::COUNT_BITS'(1);
                  ram_wr_data.rank   = '0;
                  tgt_idx_in         = free_idx;
                  insert_in          = 1'b1;
                  evict_in           = evict_w;
                  rsp_in.evicted     = evict_w;
                  state_in           = ST_UPDATE;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               cnt_in     = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[lct_pkg::IDX_BITS-1:0];
            end
            if (insert_ff) begin
               upd_ent.rank = q - ((evict_ff && q > vic_rank_ff) ? 1'b1 : 1'b0) + 1'b1;
            end else begin
               upd_ent.rank = q + ((q < found_ent_ff.rank) ? 1'b1 : 1'b0);
            end
            if (rd_pend_ff && valid_ff[rd_idx_ff] && rd_idx_ff != tgt_idx_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_idx_ff;
               ram_wr_data = upd_ent;
            end
            if (!issue && !rd_pend_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         cap_ff       <= lct_pkg::CAP_RESET;
         found_ff     <= 1'b0;
         vic_ff       <= 1'b0;
         insert_ff    <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         cap_ff       <= cap_in;
         found_ff     <= found_in;
         vic_ff       <= vic_in;
         insert_ff    <= insert_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      req_ff       <= req_in;
      nvalid_ff    <= nvalid_in;
      found_idx_ff <= found_idx_in;
      found_ent_ff <= found_ent_in;
      vic_idx_ff   <= vic_idx_in;
      vic_cnt_ff   <= vic_cnt_in;
      vic_rank_ff  <= vic_rank_in;
      tgt_idx_ff   <= tgt_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

`default_nettype wire

>>> tb/lfu_cache_table_top_tb.sv
`default_nettype none

module lfu_cache_table_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int KEY_POOL = 40;
   localparam int REQ_BITS = $bits(lct_pkg::req_type);

   class lfu_scoreboard;
      logic                           used [lct_pkg::SLOTS];
      logic [lct_pkg::KEY_BITS-1:0]   keys [lct_pkg::SLOTS];
      logic [lct_pkg::VALUE_BITS-1:0] vals [lct_pkg::SLOTS];
      logic [lct_pkg::COUNT_BITS-1:0] counts [lct_pkg::SLOTS];
      int                             ranks [lct_pkg::SLOTS];
      logic [lct_pkg::CAP_BITS-1:0]   capacity;
      lct_pkg::rsp_type               expected_q [$];
      int                             errors;
      int                             items;
      int                             hits;
      int                             evictions;
      int                             capacity_writes;

      function new();
         for (int i = 0; i < lct_pkg::SLOTS; i++) begin
            used[i] = 1'b0;
            keys[i] = '0;
            vals[i] = '0;
            counts[i] = '0;
            ranks[i] = 0;
         end
         capacity = lct_pkg::CAP_RESET;
         errors = 0;
         items = 0;
         hits = 0;
         evictions = 0;
         capacity_writes = 0;
      endfunction

      function void set_capacity(logic [lct_pkg::CAP_BITS-1:0] c);
         capacity = c;
         capacity_writes++;
      endfunction

      // The entry becomes the most recent and counts one use.
      function void promote(int s);
         for (int i = 0; i < lct_pkg::SLOTS; i++) begin
            if (used[i] && i != s && ranks[i] < ranks[s]) begin
               ranks[i]++;
            end
         end
         ranks[s] = 0;
         if (counts[s] != lct_pkg::COUNT_MAX) begin
            counts[s]++;
         end
      endfunction

      function void note_request(lct_pkg::req_type r);
         lct_pkg::rsp_type exp_rsp;
         int      limit;
         int      fill;
         int      found;
         int      victim;
         int      vacant;
         exp_rsp = '0;
         limit = (capacity > lct_pkg::SLOTS) ? lct_pkg::SLOTS : int'(capacity);
         fill = 0;
         found = -1;
         for (int i = 0; i < lct_pkg::SLOTS; i++) begin
            if (used[i]) begin
               fill++;
               if (found < 0 && keys[i] == r.lookup_key) begin
                  found = i;
               end
            end
         end
         if (r.func == lct_pkg::FUNC_GET) begin
            if (found >= 0) begin
               exp_rsp.read_value = vals[found];
               promote(found);
            end
         end else if (limit != 0) begin
            if (found >= 0) begin
               vals[found] = r.write_value;
               promote(found);
            end else begin
               if (fill >= limit) begin
                  victim = -1;
                  for (int i = 0; i < lct_pkg::SLOTS; i++) begin
                     if (used[i] && (victim < 0 || counts[i] < counts[victim] ||
                         (counts[i] == counts[victim] && ranks[i] > ranks[victim]))) begin
                        victim = i;
                     end
                  end
                  used[victim] = 1'b0;
                  for (int i = 0; i < lct_pkg::SLOTS; i++) begin
                     if (used[i] && ranks[i] > ranks[victim]) begin
                        ranks[i]--;
                     end
                  end
                  exp_rsp.evicted = 1'b1;
                  evictions++;
               end
               vacant = -1;
               for (int i = 0; i < lct_pkg::SLOTS; i++) begin
                  if (!used[i] && vacant < 0) begin
                     vacant = i;
                  end
               end
               for (int i = 0; i < lct_pkg::SLOTS; i++) begin
                  if (used[i]) begin
                     ranks[i]++;
                  end
               end
               used[vacant] = 1'b1;
               keys[vacant] = r.lookup_key;
               vals[vacant] = r.write_value;
               counts[vacant] = lct_pkg::COUNT_BITS'(1);
               ranks[vacant] = 0;
            end
         end
         exp_rsp.hit = (found >= 0);
         if (found >= 0) begin
            hits++;
         end
         items++;
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_response(lct_pkg::rsp_type got);
         lct_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result transfer, got hit %0b value %0d evicted %0b",
                     $time, got.hit, got.read_value, got.evicted);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, got.hit);
            errors++;
         end
         if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, want.read_value, got.read_value);
            errors++;
         end
         if (got.evicted !== want.evicted) begin
            $display("%0t: evicted mismatch, expected %0b, actual %0b",
                     $time, want.evicted, got.evicted);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   lct_pkg::req_type             req_payload;
   logic                         rsp_valid;
   lct_pkg::rsp_type             rsp_payload;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [lct_pkg::CAP_BITS-1:0] csr_data;

   lfu_scoreboard sb = new();
   int cycle_count = 0;
   logic [lct_pkg::KEY_BITS-1:0] key_pool [KEY_POOL];
   bit no_idle;

   lfu_cache_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_response(rsp_payload);
         end
         if (start && !busy) begin
            sb.note_request(req_payload);
         end
         if (csr_valid && csr_ready) begin
            sb.set_capacity(csr_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.expected_q.size());
         $display("FAIL lfu_cache_table_top");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 45) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer, once any random gap has passed.
   task automatic issue_op(input lct_pkg::func_type f,
                           input logic [lct_pkg::KEY_BITS-1:0] k,
                           input logic [lct_pkg::VALUE_BITS-1:0] v);
      int gap;
      gap = pick_gap();
      req_payload.func = f;
      req_payload.lookup_key = k;
      req_payload.write_value = v;
      start = 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         req_payload = REQ_BITS'({$urandom, $urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (sb.expected_q.size() != 0 || busy) begin
         @(negedge clock);
      end
   endtask

   task automatic write_capacity(input logic [lct_pkg::CAP_BITS-1:0] c);
      wait_idle();
      csr_valid = 1'b1;
      csr_data = c;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data = lct_pkg::CAP_BITS'($urandom);
   endtask

   function automatic logic [lct_pkg::VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int done;
      int phase;
      int span;
      int base;
      int count;
      int limit;
      logic [lct_pkg::CAP_BITS-1:0] cap;
      lct_pkg::func_type f;
      logic [lct_pkg::KEY_BITS-1:0] k;

      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      no_idle = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: misses, hits, updates, evictions with a lowered capacity,
      // inserts blocked at zero capacity and a capacity above the slot count.
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0000, 32'h1234_5678);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0000, 32'h7fff_ffff);
      issue_op(lct_pkg::FUNC_PUT, 32'hffff_ffff, 32'h8000_0000);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0001, 32'hffff_ffff);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0000);
      issue_op(lct_pkg::FUNC_GET, 32'hffff_ffff, 32'h0);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0001, 32'hffff_ffff);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0005);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0003, 32'h0);
      write_capacity(5'd2);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0003, 32'haaaa_5555);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0004, 32'h5555_aaaa);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0001);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0002, 32'h0);
      write_capacity(5'd0);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0009);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0009, 32'h0000_0009);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0000, 32'h0);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0009, 32'h0);
      write_capacity(5'd31);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0006);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0007, 32'h0000_0007);
      write_capacity(5'd1);
      issue_op(lct_pkg::FUNC_PUT, 32'h0000_0008, 32'h0000_0008);
      issue_op(lct_pkg::FUNC_GET, 32'h0000_0008, 32'h0);

      done = 0;
      phase = 0;
      while (done < RANDOM_ITEMS) begin
         case (phase % 7)
            0: cap = 5'd16;
            1: cap = lct_pkg::CAP_BITS'($urandom_range(1, 15));
            2: cap = 5'd0;
            3: cap = lct_pkg::CAP_BITS'($urandom_range(17, 31));
            4: cap = 5'd1;
            5: cap = 5'd31;
            default: cap = lct_pkg::CAP_BITS'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         no_idle = ($urandom_range(0, 3) == 0);
         limit = (cap > lct_pkg::SLOTS) ? lct_pkg::SLOTS : int'(cap);
         span = limit + $urandom_range(1, 8);
         if (span > KEY_POOL) begin
            span = KEY_POOL;
         end
         base = $urandom_range(0, KEY_POOL - 1);
         count = (cap == 0) ? $urandom_range(20, 40) : $urandom_range(80, 220);
         for (int n = 0; n < count && done < RANDOM_ITEMS; n++) begin
            f = lct_pkg::func_type'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 8) begin
               k = $urandom;
            end else begin
               k = key_pool[(base + $urandom_range(0, span - 1)) % KEY_POOL];
            end
            issue_op(f, k, pick_value());
            done++;
         end
         phase++;
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("Ran %0d operations over %0d capacity settings: %0d hits, %0d evictions.",
               sb.items, sb.capacity_writes, sb.hits, sb.evictions);
      $display("Mismatches found: %0d; results still outstanding: %0d.",
               sb.errors, sb.expected_q.size());
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS lfu_cache_table_top");
      end else begin
         $display("FAIL lfu_cache_table_top");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> lfu_cache_table_top.f
rtl/lct_pkg.sv
rtl/lct_ram.sv
rtl/lfu_cache_table_top.sv
tb/lfu_cache_table_top_tb.sv
